### rtl/core/euvf_pkg.sv
package euvf_pkg;

    // field widths
    localparam int ANGLE_W = 12;
    localparam int TIME_W  = 32;
    localparam int POS_W   = 32;
    localparam int SPEED_W = 32;

    // configuration register widths
    localparam int RATE_W  = 24;
    localparam int ALPHA_W = 17;
    localparam int WHEEL_W = 24;

    // apb port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes, byte address 4*index
    localparam logic [1:0] REG_RATE  = 2'd0;
    localparam logic [1:0] REG_ALPHA = 2'd1;
    localparam logic [1:0] REG_WHEEL = 2'd2;

    // reset values
    localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(16000);
    localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(9830);
    localparam logic [WHEEL_W-1:0] WHEEL_RST = WHEEL_W'(12353);

    // opcodes
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_INIT   = 2'd2;

    // shared multiplier geometry
    localparam int MA_W = 36;
    localparam int MB_W = 25;
    localparam int MW   = MA_W + MB_W;

    // q16.16 constants
    localparam logic [ALPHA_W-1:0]    ONE_Q16    = ALPHA_W'(65536);
    localparam logic signed [MB_W-1:0] TWO_PI_Q16 = MB_W'(411774);
    localparam logic signed [MW-1:0]  RND_HALF   = MW'(32768);
    localparam logic signed [MW-1:0]  SAT_HI     = {{(MW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [MW-1:0]  SAT_LO     = {{(MW-31){1'b1}}, {31{1'b0}}};

    typedef struct packed {
        logic [RATE_W-1:0]  rate_scale;
        logic [ALPHA_W-1:0] smoothing_alpha;
        logic [WHEEL_W-1:0] wheel_scale;
    } euvf_cfg_t;

    // floor(v / 65536 + 0.5)
    function automatic logic signed [MW-1:0] rnd16(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] t;
        t = v + RND_HALF;
        return t >>> 16;
    endfunction

    // clamp to signed 32 bits
    function automatic logic signed [SPEED_W-1:0] sat32(input logic signed [MW-1:0] v);
        logic signed [SPEED_W-1:0] r;
        if (v > SAT_HI) begin
            r = {1'b0, {(SPEED_W-1){1'b1}}};
        end else if (v < SAT_LO) begin
            r = {1'b1, {(SPEED_W-1){1'b0}}};
        end else begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/euvf_regs.sv
module euvf_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [euvf_pkg::ADDR_W-1:0]   paddr,
    input  logic [euvf_pkg::DATA_W-1:0]   pwdata,
    output logic [euvf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output euvf_pkg::euvf_cfg_t           cfg
);
    import euvf_pkg::*;

    logic [RATE_W-1:0]  rate_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [WHEEL_W-1:0] wheel_reg;
    logic [1:0]         idx;
    logic               wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= RATE_RST;
            alpha_reg <= ALPHA_RST;
            wheel_reg <= WHEEL_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_RATE:  rate_reg  <= pwdata[RATE_W-1:0];
                REG_ALPHA: alpha_reg <= pwdata[ALPHA_W-1:0];
                REG_WHEEL: wheel_reg <= pwdata[WHEEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_RATE:  prdata = DATA_W'(rate_reg);
            REG_ALPHA: prdata = DATA_W'(alpha_reg);
            REG_WHEEL: prdata = DATA_W'(wheel_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg.rate_scale      = rate_reg;
    assign cfg.smoothing_alpha = alpha_reg;
    assign cfg.wheel_scale     = wheel_reg;

endmodule

### rtl/core/euvf_mul.sv
module euvf_mul (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [euvf_pkg::MA_W-1:0]   a,
    input  logic signed [euvf_pkg::MB_W-1:0]   b,
    output logic signed [euvf_pkg::MW-1:0]     p
);
    import euvf_pkg::*;

    logic signed [MW-1:0] p_reg;

    // product held until the next issue
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

### rtl/core/euvf_div.sv
module euvf_div #(
    parameter int DIVIDEND_W = 38
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [DIVIDEND_W-1:0]           dividend,
    input  logic [euvf_pkg::TIME_W-1:0]     divisor,
    output logic                            done,
    output logic [DIVIDEND_W-1:0]           quotient
);
    import euvf_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [TIME_W-1:0]     rem_reg;
    logic [TIME_W-1:0]     rem_next;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [TIME_W:0]       shifted;
    logic [TIME_W:0]       diff;
    logic                  fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted  = {rem_reg, quot_reg[DIVIDEND_W-1]};
        diff     = shifted - {1'b0, divisor};
        fits     = shifted >= {1'b0, divisor};
        rem_next = fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // pulse after the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### rtl/core/encoder_unwrap_velocity_filter.sv
// channel  ports                         role
// -------  ----------------------------  ----------------------------------------
// s_       valid/ready, 4 fields         opcode, channel, raw angle, timestamp in
// m_       valid/ready, 5 fields         channel, position, three speeds out
// apb      psel/penable/pwrite/paddr     rate_scale, smoothing_alpha, wheel_scale
//
// an update with nonzero elapsed time steps through PREP, MRAW, DLOAD, DIV, SAT, MA, MB,
// MIX, RAD, RADR, LIN and FIN, and waits in FIN until the output register is free;
// the serial divider retires one quotient bit a cycle, the multiplier is issued five times
// clear, init, spare opcode and zero elapsed time go from PREP to RAD, a missing channel to FIN
// s_ready is high only while idle; the sequencer holds in its last state while the output
// item waits on m_ready; synchronous active-low reset clears state, config regs and m_valid
module encoder_unwrap_velocity_filter #(
    parameter int CHANNELS        = 2,
    parameter int COUNTS_PER_TURN = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_opcode,
    input  logic                               s_channel,
    input  logic [euvf_pkg::ANGLE_W-1:0]       s_raw_angle,
    input  logic [euvf_pkg::TIME_W-1:0]        s_now_ms,
    // result items
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_out_channel,
    output logic signed [euvf_pkg::POS_W-1:0]  m_position,
    output logic signed [euvf_pkg::SPEED_W-1:0] m_speed_rps,
    output logic signed [euvf_pkg::SPEED_W-1:0] m_speed_rads,
    output logic signed [euvf_pkg::SPEED_W-1:0] m_speed_linear,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [euvf_pkg::ADDR_W-1:0]        paddr,
    input  logic [euvf_pkg::DATA_W-1:0]        pwdata,
    output logic [euvf_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import euvf_pkg::*;

    // delta must hold angle difference plus or minus one turn
    localparam int CPT_W = $clog2(COUNTS_PER_TURN) + 1;
    localparam int DW    = ((CPT_W > ANGLE_W) ? CPT_W : ANGLE_W) + 2;
    // magnitude of delta * rate_scale
    localparam int PW    = DW - 1 + RATE_W;
    localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic signed [DW-1:0] CPT_S  = DW'(COUNTS_PER_TURN);
    localparam logic signed [DW-1:0] HALF_S = DW'(COUNTS_PER_TURN / 2);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_PREP  = 13'b0000000000010,
        S_MRAW  = 13'b0000000000100,
        S_DLOAD = 13'b0000000001000,
        S_DIV   = 13'b0000000010000,
        S_SAT   = 13'b0000000100000,
        S_MA    = 13'b0000001000000,
        S_MB    = 13'b0000010000000,
        S_MIX   = 13'b0000100000000,
        S_RAD   = 13'b0001000000000,
        S_RADR  = 13'b0010000000000,
        S_LIN   = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } state_t;

    euvf_cfg_t cfg;

    state_t state_reg;

    // latched item
    logic [1:0]          op_reg;
    logic                ch_reg;
    logic [ANGLE_W-1:0]  raw_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                zero_reg;

    // per-channel state
    logic [ANGLE_W-1:0]        prev_angle_reg [CHANNELS];
    logic [TIME_W-1:0]         last_time_reg  [CHANNELS];
    logic [POS_W-1:0]          pos_reg        [CHANNELS];
    logic signed [SPEED_W-1:0] filt_reg       [CHANNELS];

    // working registers
    logic signed [DW-1:0]      delta_reg;
    logic [TIME_W-1:0]         elapsed_reg;
    logic                      neg_reg;
    logic signed [SPEED_W-1:0] rv_reg;
    logic signed [MW-1:0]      acc_reg;
    logic signed [MA_W-1:0]    rads_reg;

    // output register
    logic                      m_valid_reg;
    logic                      m_chan_reg;
    logic signed [POS_W-1:0]   m_pos_reg;
    logic signed [SPEED_W-1:0] m_rps_reg;
    logic signed [SPEED_W-1:0] m_rads_reg;
    logic signed [SPEED_W-1:0] m_lin_reg;

    logic [CIW-1:0]            idx;
    logic                      in_range;
    logic                      accept;
    logic                      out_free;

    logic signed [DW-1:0]      d_raw;
    logic signed [DW-1:0]      d_hi;
    logic signed [DW-1:0]      d_fix;
    logic [TIME_W-1:0]         elapsed_now;

    logic [ALPHA_W-1:0]        alpha_w;
    logic [ALPHA_W-1:0]        alpha_inv;

    // shared multiplier
    logic                      mul_en;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [MW-1:0]      mul_p;

    // divider
    logic                      div_start;
    logic                      div_done;
    logic [PW-1:0]             div_dividend;
    logic [PW-1:0]             div_quot;
    logic signed [MW-1:0]      prod_mag;
    logic signed [PW:0]        quot_s;
    logic signed [PW:0]        quot_v;

    logic signed [MW-1:0]      mix_sum;
    logic signed [SPEED_W-1:0] filt_new;
    logic signed [MW-1:0]      rads_rnd;

    euvf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    euvf_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    euvf_div #(
        .DIVIDEND_W (PW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign idx      = CIW'(ch_reg);
    // the channel field is one bit, so only channel one can be missing
    assign in_range = (CHANNELS > 1) || (ch_reg == 1'b0);

    // unwrap: fold a jump of more than half a turn back by one turn
    always_comb begin
        d_raw = $signed({{(DW-ANGLE_W){1'b0}}, raw_reg})
              - $signed({{(DW-ANGLE_W){1'b0}}, prev_angle_reg[idx]});
        d_hi  = (d_raw > HALF_S) ? d_raw - CPT_S : d_raw;
        d_fix = (d_hi < -HALF_S) ? d_hi + CPT_S : d_hi;
        elapsed_now = now_reg - last_time_reg[idx];
    end

    // filter weight, clamped to one
    assign alpha_w   = (cfg.smoothing_alpha > ONE_Q16) ? ONE_Q16 : cfg.smoothing_alpha;
    assign alpha_inv = ONE_Q16 - alpha_w;

    // operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_MRAW: begin
                // delta * rate_scale
                mul_en = 1'b1;
                mul_a  = MA_W'(delta_reg);
                mul_b  = $signed({1'b0, cfg.rate_scale});
            end
            S_MA: begin
                // new sample weight
                mul_en = 1'b1;
                mul_a  = MA_W'(rv_reg);
                mul_b  = $signed(MB_W'(alpha_w));
            end
            S_MB: begin
                // old value weight
                mul_en = 1'b1;
                mul_a  = MA_W'(filt_reg[idx]);
                mul_b  = $signed(MB_W'(alpha_inv));
            end
            S_RAD: begin
                // rev/s to rad/s
                mul_en = 1'b1;
                mul_a  = MA_W'(filt_reg[idx]);
                mul_b  = TWO_PI_Q16;
            end
            S_LIN: begin
                // unsaturated rad/s times wheel radius
                mul_en = 1'b1;
                mul_a  = rads_reg;
                mul_b  = $signed({1'b0, cfg.wheel_scale});
            end
            default: ;
        endcase
    end

    // divider takes the magnitude; the sign comes back in at saturation
    always_comb begin
        prod_mag     = neg_reg ? -mul_p : mul_p;
        div_dividend = prod_mag[PW-1:0];
        quot_s       = $signed({1'b0, div_quot});
        quot_v       = neg_reg ? -quot_s : quot_s;
    end

    assign div_start = (state_reg == S_DLOAD);

    assign mix_sum  = acc_reg + mul_p;
    assign filt_new = sat32(rnd16(mix_sum));
    assign rads_rnd = rnd16(mul_p);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (!in_range) begin
                        state_reg <= S_FIN;
                    end else if (op_reg == OP_UPDATE && elapsed_now != '0) begin
                        state_reg <= S_MRAW;
                    end else begin
                        state_reg <= S_RAD;
                    end
                end
                S_MRAW:  state_reg <= S_DLOAD;
                S_DLOAD: state_reg <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT:  state_reg <= S_MA;
                S_MA:   state_reg <= S_MB;
                S_MB:   state_reg <= S_MIX;
                S_MIX:  state_reg <= S_RAD;
                S_RAD:  state_reg <= S_RADR;
                S_RADR: state_reg <= S_LIN;
                S_LIN:  state_reg <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // item capture and working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_opcode;
            ch_reg  <= s_channel;
            raw_reg <= s_raw_angle;
            now_reg <= s_now_ms;
        end
        if (state_reg == S_PREP) begin
            zero_reg    <= !in_range;
            delta_reg   <= d_fix;
            elapsed_reg <= elapsed_now;
            neg_reg     <= d_fix < 0;
        end
        if (state_reg == S_SAT) begin
            rv_reg <= sat32(MW'(quot_v));
        end
        if (state_reg == S_MB) begin
            acc_reg <= mul_p;
        end
        if (state_reg == S_RADR) begin
            rads_reg <= rads_rnd[MA_W-1:0];
        end
    end

    // channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                prev_angle_reg[i] <= '0;
                last_time_reg[i]  <= '0;
                pos_reg[i]        <= '0;
                filt_reg[i]       <= '0;
            end
        end else begin
            if (state_reg == S_PREP && in_range) begin
                unique case (op_reg)
                    OP_UPDATE: begin
                        pos_reg[idx]        <= pos_reg[idx] + POS_W'(d_fix);
                        prev_angle_reg[idx] <= raw_reg;
                        last_time_reg[idx]  <= now_reg;
                    end
                    OP_CLEAR: begin
                        pos_reg[idx]  <= '0;
                        filt_reg[idx] <= '0;
                    end
                    OP_INIT: begin
                        prev_angle_reg[idx] <= raw_reg;
                        last_time_reg[idx]  <= now_reg;
                        pos_reg[idx]        <= '0;
                        filt_reg[idx]       <= '0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == S_MIX) begin
                filt_reg[idx] <= filt_new;
            end
        end
    end

    // output register; a channel that is not there reports zeros
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && out_free) begin
            m_chan_reg <= ch_reg;
            if (zero_reg) begin
                m_pos_reg  <= '0;
                m_rps_reg  <= '0;
                m_rads_reg <= '0;
                m_lin_reg  <= '0;
            end else begin
                m_pos_reg  <= $signed(pos_reg[idx]);
                m_rps_reg  <= filt_reg[idx];
                m_rads_reg <= sat32(MW'(rads_reg));
                m_lin_reg  <= sat32(rads_rnd);
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_channel  = m_chan_reg;
    assign m_position     = m_pos_reg;
    assign m_speed_rps    = m_rps_reg;
    assign m_speed_rads   = m_rads_reg;
    assign m_speed_linear = m_lin_reg;

endmodule

### bench/encoder_motion_checker.sv
module encoder_motion_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic                                s_channel,
    input  logic [euvf_pkg::ANGLE_W-1:0]        s_raw_angle,
    input  logic [euvf_pkg::TIME_W-1:0]         s_now_ms,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_out_channel,
    input  logic signed [euvf_pkg::POS_W-1:0]   m_position,
    input  logic signed [euvf_pkg::SPEED_W-1:0] m_speed_rps,
    input  logic signed [euvf_pkg::SPEED_W-1:0] m_speed_rads,
    input  logic signed [euvf_pkg::SPEED_W-1:0] m_speed_linear,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [euvf_pkg::ADDR_W-1:0]         paddr,
    input  logic [euvf_pkg::DATA_W-1:0]         pwdata,
    input  logic [euvf_pkg::DATA_W-1:0]         prdata,
    output int                                  mismatches,
    output int                                  unanswered
);
    timeunit 1ns;
    timeprecision 1ps;

    import euvf_pkg::*;

    localparam int     TURN        = 4096;
    localparam int     HALF_TURN   = TURN / 2;
    localparam longint FULL_WEIGHT = 65536;
    localparam longint REV_TO_RAD  = 411774;  // 2*pi in q16.16
    localparam longint MAX32       = 64'sd2147483647;
    localparam longint MIN32       = -MAX32 - 1;

    typedef struct packed {
        logic                      channel;
        logic [POS_W-1:0]          position;
        logic signed [SPEED_W-1:0] rps;
        logic signed [SPEED_W-1:0] rads;
        logic signed [SPEED_W-1:0] linear;
    } motion_report_t;

    logic [ANGLE_W-1:0]         last_angle   [2];
    logic [TIME_W-1:0]          last_stamp   [2];
    logic [POS_W-1:0]           position_acc [2];
    logic signed [SPEED_W-1:0]  smoothed_rps [2];
    logic [RATE_W-1:0]          rate_cfg;
    logic [ALPHA_W-1:0]         alpha_cfg;
    logic [WHEEL_W-1:0]         wheel_cfg;
    logic [DATA_W-1:0]          readback;
    motion_report_t             pending_reports [$];
    motion_report_t             oldest;
    int                         fault_tally = 0;
    int                         backlog = 0;

    assign mismatches = fault_tally;
    assign unanswered = backlog;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > MAX32) return 32'sh7FFF_FFFF;
        if (v < MIN32) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // round to nearest, halves up
    function automatic longint half_up_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic motion_report_t advance_channel(
        input logic [1:0]         op,
        input logic               ch,
        input logic [ANGLE_W-1:0] angle,
        input logic [TIME_W-1:0]  now
    );
        motion_report_t r;
        int delta;
        logic [TIME_W-1:0] elapsed;
        longint step, span, scale, gain, drive, stale, mix, rps, rads_wide, wheel;
        // two channels and a 1-bit channel field, so every item hits a real channel
        case (op)
            OP_UPDATE: begin
                delta = int'({20'd0, angle}) - int'({20'd0, last_angle[ch]});
                if (delta > HALF_TURN) delta -= TURN;
                if (delta < -HALF_TURN) delta += TURN;
                position_acc[ch] += delta;
                last_angle[ch] = angle;
                elapsed = now - last_stamp[ch];
                if (elapsed != '0) begin
                    step  = delta;
                    span  = elapsed;
                    scale = rate_cfg;
                    gain  = alpha_cfg;
                    if (gain > FULL_WEIGHT) gain = FULL_WEIGHT;
                    drive = clamp32(step * scale / span);
                    stale = smoothed_rps[ch];
                    mix   = gain * drive + (FULL_WEIGHT - gain) * stale;
                    smoothed_rps[ch] = clamp32(half_up_q16(mix));
                end
                last_stamp[ch] = now;
            end
            OP_CLEAR: begin
                position_acc[ch] = '0;
                smoothed_rps[ch] = '0;
            end
            OP_INIT: begin
                last_angle[ch]   = angle;
                last_stamp[ch]   = now;
                position_acc[ch] = '0;
                smoothed_rps[ch] = '0;
            end
            default: ;  // spare opcode only reports
        endcase
        rps       = smoothed_rps[ch];
        wheel     = wheel_cfg;
        rads_wide = half_up_q16(rps * REV_TO_RAD);
        r.channel  = ch;
        r.position = position_acc[ch];
        r.rps      = smoothed_rps[ch];
        r.rads     = clamp32(rads_wide);
        // linear speed is taken from the unclamped rad/s value
        r.linear   = clamp32(half_up_q16(rads_wide * wheel));
        return r;
    endfunction

    task automatic check_field(
        input string             name,
        input logic signed [31:0] want,
        input logic signed [31:0] got
    );
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fault_tally++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                last_angle[i]   = '0;
                last_stamp[i]   = '0;
                position_acc[i] = '0;
                smoothed_rps[i] = '0;
            end
            rate_cfg  = RATE_RST;
            alpha_cfg = ALPHA_RST;
            wheel_cfg = WHEEL_RST;
            pending_reports.delete();
        end else begin
            // retire before accepting, a result always belongs to an older item
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("result on channel %0d with no item pending", m_out_channel);
                    fault_tally++;
                end else begin
                    oldest = pending_reports.pop_front();
                    check_field("out_channel", oldest.channel, m_out_channel);
                    check_field("position", oldest.position, m_position);
                    check_field("speed_rps", oldest.rps, m_speed_rps);
                    check_field("speed_rads", oldest.rads, m_speed_rads);
                    check_field("speed_linear", oldest.linear, m_speed_linear);
                end
            end
            if (s_valid && s_ready) begin
                pending_reports.push_back(
                    advance_channel(s_opcode, s_channel, s_raw_angle, s_now_ms));
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[ADDR_W-1:2])
                        REG_RATE:  rate_cfg  = pwdata[RATE_W-1:0];
                        REG_ALPHA: alpha_cfg = pwdata[ALPHA_W-1:0];
                        REG_WHEEL: wheel_cfg = pwdata[WHEEL_W-1:0];
                        default: ;
                    endcase
                end else begin
                    case (paddr[ADDR_W-1:2])
                        REG_RATE:  readback = DATA_W'(rate_cfg);
                        REG_ALPHA: readback = DATA_W'(alpha_cfg);
                        REG_WHEEL: readback = DATA_W'(wheel_cfg);
                        default:   readback = '0;
                    endcase
                    check_field("prdata", readback, prdata);
                end
            end
        end
        backlog = pending_reports.size();
    end

endmodule

### bench/encoder_unwrap_velocity_filter_tb.sv
module encoder_unwrap_velocity_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import euvf_pkg::*;

    // opcode three is decoded as a no-op that only reports the channel
    localparam logic [1:0] OP_SPARE = 2'd3;
    // longest run of cycles with no item moving on either side
    localparam int QUIET_LIMIT   = 1000;
    // extra settling after the last result, more than one update needs
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 238;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [1:0]                 s_opcode;
    logic                       s_channel;
    logic [ANGLE_W-1:0]         s_raw_angle;
    logic [TIME_W-1:0]          s_now_ms;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_out_channel;
    logic signed [POS_W-1:0]    m_position;
    logic signed [SPEED_W-1:0]  m_speed_rps;
    logic signed [SPEED_W-1:0]  m_speed_rads;
    logic signed [SPEED_W-1:0]  m_speed_linear;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    int                         mismatches;
    int                         unanswered;

    // bookkeeping for the stimulus side only
    int                 items_sent     = 0;
    int                 results_seen   = 0;
    int                 settings_used  = 0;
    int                 gap_pct        = 0;  // odds of a gap before an input item
    int                 stall_pct      = 0;  // odds of a stall burst on m_ready
    logic [ANGLE_W-1:0] track_angle [2];     // last angle an update or init gave each channel
    logic [TIME_W-1:0]  track_stamp [2];     // last timestamp an update or init gave each channel

    always #6 aclk = ~aclk;

    encoder_unwrap_velocity_filter uut (.*);

    encoder_motion_checker checker_i (.*);

    // result side: random stall bursts on m_ready while stall_pct is nonzero
    initial begin : sink_stalls
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // counts results and ends the run if traffic stops for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (m_valid && m_ready) results_seen++;
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $error("no item moved for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // setup cycle, access cycle, then release the bus
    task automatic apb_access(
        input logic              write,
        input logic [1:0]        index,
        input logic [DATA_W-1:0] data
    );
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // the checker compares every read against its own copy of the registers
    task automatic read_back_all();
        apb_access(1'b0, REG_RATE, '0);
        apb_access(1'b0, REG_ALPHA, '0);
        apb_access(1'b0, REG_WHEEL, '0);
    endtask

    task automatic program_setting(
        input logic [RATE_W-1:0]  rate,
        input logic [ALPHA_W-1:0] alpha,
        input logic [WHEEL_W-1:0] wheel
    );
        logic [DATA_W-1:0] junk;
        junk = $urandom();
        // bits above each register are don't-care, fill them with noise
        apb_access(1'b1, REG_RATE, {junk[DATA_W-1:RATE_W], rate});
        apb_access(1'b1, REG_ALPHA, {junk[DATA_W-1:ALPHA_W], alpha});
        apb_access(1'b1, REG_WHEEL, {~junk[DATA_W-1:WHEEL_W], wheel});
        read_back_all();
        settings_used++;
    endtask

    // one item, optionally after a gap; holds valid and payload until accepted
    task automatic send_item(
        input logic [1:0]         op,
        input logic               ch,
        input logic [ANGLE_W-1:0] angle,
        input logic [TIME_W-1:0]  now
    );
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_channel   <= ch;
        s_raw_angle <= angle;
        s_now_ms    <= now;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (op == OP_UPDATE || op == OP_INIT) begin
            track_angle[ch] = angle;
            track_stamp[ch] = now;
        end
    endtask

    // wait for every result, then let the block go idle before touching registers
    task automatic drain();
        s_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly plausible motion: small steps at ms spacing, with a share of
    // half-turn probes, stalled clocks, backward time and random noise
    task automatic send_random_item();
        logic               ch;
        logic [1:0]         op;
        logic [ANGLE_W-1:0] angle;
        logic [TIME_W-1:0]  now;
        int                 pick;
        int                 step;
        ch    = 1'($urandom());
        pick  = $urandom_range(0, 99);
        op    = pick < 84 ? OP_UPDATE : pick < 90 ? OP_INIT : pick < 95 ? OP_CLEAR : OP_SPARE;
        angle = ANGLE_W'($urandom());
        now   = $urandom();
        if (op == OP_UPDATE) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                step  = $urandom_range(0, 600);
                angle = track_angle[ch] + ANGLE_W'(step - 300);
            end else if (pick < 84) begin
                // straddle the half-turn boundary in both directions
                step = $urandom_range(2045, 2051);
                if ($urandom_range(0, 1) != 0) step = -step;
                angle = track_angle[ch] + ANGLE_W'(step);
            end
            pick = $urandom_range(0, 99);
            if (pick < 72) now = track_stamp[ch] + $urandom_range(1, 40);
            else if (pick < 80) now = track_stamp[ch];
            else if (pick < 88) now = track_stamp[ch] + $urandom_range(41, 100000);
            else if (pick < 94) now = track_stamp[ch] - $urandom_range(1, 1000);
        end else if (op == OP_INIT && $urandom_range(0, 1) != 0) begin
            // start close to the top so the timestamp wraps soon
            now = 32'hFFFF_FFFF - $urandom_range(0, 200);
        end
        send_item(op, ch, angle, now);
    endtask

    initial begin
        logic [RATE_W-1:0]  rate;
        logic [ALPHA_W-1:0] alpha;
        logic [WHEEL_W-1:0] wheel;

        // everything known from time zero while reset is held
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_opcode    <= OP_UPDATE;
        s_channel   <= 1'b0;
        s_raw_angle <= '0;
        s_now_ms    <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        for (int i = 0; i < 2; i++) begin
            track_angle[i] = '0;
            track_stamp[i] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // registers should read back their reset values
        read_back_all();

        // directed items at the reset setting, light idling on both sides
        gap_pct   = 20;
        stall_pct = 20;
        send_item(OP_UPDATE, 1'b0, 12'd100, 32'd10);           // first update from reset
        send_item(OP_UPDATE, 1'b1, 12'd4095, 32'd1);           // wraps to a step of -1
        send_item(OP_INIT, 1'b0, 12'd4000, 32'hFFFF_FFF0);
        send_item(OP_UPDATE, 1'b0, 12'd10, 32'd5);             // angle and time both wrap
        send_item(OP_UPDATE, 1'b0, 12'd2058, 32'd5);           // half turn forward, no time
        send_item(OP_UPDATE, 1'b0, 12'd10, 32'd6);             // half turn back
        send_item(OP_UPDATE, 1'b0, 12'd2059, 32'd7);           // just past half turn
        send_item(OP_UPDATE, 1'b0, 12'd10, 32'd8);             // just past, backward
        send_item(OP_INIT, 1'b1, 12'd4095, 32'hFFFF_FFFF);
        send_item(OP_UPDATE, 1'b1, 12'd0, 32'd0);
        send_item(OP_UPDATE, 1'b1, 12'd4095, 32'hFFFF_FFFF);   // largest elapsed time
        send_item(OP_CLEAR, 1'b1, 12'hABC, 32'h5555_AAAA);     // angle and time ignored
        send_item(OP_SPARE, 1'b0, 12'hFFF, 32'hFFFF_FFFF);
        send_item(OP_UPDATE, 1'b1, 12'd2047, 32'd3);

        // top of every register, alpha above one: speeds pin at both rails
        drain();
        program_setting('1, '1, '1);
        send_item(OP_UPDATE, 1'b0, 12'd2057, 32'd9);
        send_item(OP_UPDATE, 1'b0, 12'd10, 32'd10);
        send_item(OP_UPDATE, 1'b1, 12'd3047, 32'd4);
        send_item(OP_SPARE, 1'b1, 12'h555, 32'h0000_0000);

        // all registers zero: filter holds, linear speed drops out
        drain();
        program_setting('0, '0, '0);
        send_item(OP_UPDATE, 1'b0, 12'd20, 32'd11);
        send_item(OP_UPDATE, 1'b1, 12'd3000, 32'd100);

        // random phases, each under its own register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            case ($urandom_range(0, 3))
                0:       rate = '0;
                1:       rate = '1;
                2:       rate = RATE_W'($urandom_range(1, 100000));
                default: rate = RATE_W'($urandom());
            endcase
            case ($urandom_range(0, 3))
                0:       alpha = '0;
                1:       alpha = ONE_Q16;
                2:       alpha = ALPHA_W'($urandom_range(65537, 131071));
                default: alpha = ALPHA_W'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 3))
                0:       wheel = '0;
                1:       wheel = '1;
                2:       wheel = WHEEL_W'($urandom_range(1, 100000));
                default: wheel = WHEEL_W'($urandom());
            endcase
            program_setting(rate, alpha, wheel);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // re-roll the idling every 40 items, none at all in the last phase
                if (n % 40 == 0) begin
                    if (phase == RANDOM_PHASES - 1) begin
                        gap_pct   = 0;
                        stall_pct = 0;
                    end else begin
                        case ($urandom_range(0, 2))
                            0:       gap_pct = 0;
                            1:       gap_pct = 12;
                            default: gap_pct = 40;
                        endcase
                        case ($urandom_range(0, 2))
                            0:       stall_pct = 0;
                            1:       stall_pct = 10;
                            default: stall_pct = 35;
                        endcase
                    end
                end
                send_random_item();
            end
        end
        drain();

        if (unanswered != 0) $error("%0d items still waiting for a result", unanswered);
        $display("covered %0d items and %0d results over %0d register settings",
                 items_sent, results_seen, settings_used);
        $display("both channels, all opcodes, half-turn edges, time wrap, saturated speeds");
        if (mismatches == 0 && unanswered == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
